// ----- design/assert_macros.svh -----
// Assertion macros for the checker module of the session cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define LSC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("session cache check failed");

// The consequent must hold in the same cycle as the antecedent.
`define LSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("session cache check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session cache check failed");

`endif

// ----- design/lsc_pkg.sv -----
// Types and constants of the session cache.
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

  localparam int KEY_PORT_BITS = 64;
  localparam int HANDLE_BITS   = 64;
  localparam int STAMP_BITS    = 32;
  localparam int SLOT_BITS     = 4;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   hit;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [HANDLE_BITS-1:0] evicted_handle;
    logic [SLOT_BITS-1:0]   slot_used;
  } result_t;

endpackage

`default_nettype wire

// ----- design/lsc_req_if.sv -----
// Request channel of the session cache.
`timescale 1ns / 1ps
`default_nettype none

interface lsc_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic                                key_valid;
  logic [lsc_pkg::KEY_PORT_BITS-1:0]   key;
  logic [lsc_pkg::HANDLE_BITS-1:0]     handle_in;

  modport source (output valid, output action, output key_valid, output key,
                  output handle_in, input ready);
  modport sink (input valid, input action, input key_valid, input key,
                input handle_in, output ready);
endinterface

`default_nettype wire

// ----- design/lsc_rsp_if.sv -----
// Response channel of the session cache.
`timescale 1ns / 1ps
`default_nettype none

interface lsc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [lsc_pkg::HANDLE_BITS-1:0]   handle_out;
  logic [lsc_pkg::HANDLE_BITS-1:0]   evicted_handle;
  logic [lsc_pkg::SLOT_BITS-1:0]     slot_used;

  modport source (output valid, output hit, output handle_out, output evicted_handle,
                  output slot_used, input ready);
  modport sink (input valid, input hit, input handle_out, input evicted_handle,
                input slot_used, output ready);
endinterface

`default_nettype wire

// ----- design/lru_session_cache.sv -----
// Top level of the fully associative session cache with least-recently-used replacement.
//
// The cache holds ENTRIES entries of key, handle and stamp in one memory with a single
// read port, and every request with a key, bar an insert of a zero handle, walks all
// entries through that port, one entry per cycle, through a single key and stamp compare
// unit. A lookup or insert is accepted only while the cache is idle. Between one
// acceptance and the earliest next one come the accepting cycle, the reads of all
// entries, a trailing compare, the write state and the load of the response register;
// a request without a key, or an insert of a zero handle, skips the reads, the compare
// and the write state. A waiting response holds the cache in its last state until the
// response register is free. The response register decouples the two sides: a new
// request may be accepted while the previous response still waits. After reset all
// entries read as empty through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_session_cache #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  lsc_req_if.sink    req,
  lsc_rsp_if.source  rsp
);

  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int HB       = lsc_pkg::HANDLE_BITS;
  localparam int SB       = lsc_pkg::STAMP_BITS;
  localparam int WORD_W   = KEY_BITS + HB + SB;
  localparam int LAST_IDX = ENTRIES - 1;

  lsc_pkg::state_t state;
  lsc_pkg::state_t state_next;

  logic                act;
  logic [KEY_BITS-1:0] key_r;
  logic [HB-1:0]       handle_r;
  logic [CNT_W-1:0]    idx;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;
  logic [ENTRIES-1:0]  vld;
  logic                found;
  logic [IDX_W-1:0]    match_idx;
  logic [HB-1:0]       match_handle;
  logic                free_found;
  logic [IDX_W-1:0]    empty_slot;
  logic [SB-1:0]       best_stamp;
  logic [IDX_W-1:0]    best_idx;
  logic [HB-1:0]       best_handle;
  logic [SB-1:0]       generation;
  lsc_pkg::result_t    res;
  lsc_pkg::result_t    res_next;
  logic                out_valid;
  lsc_pkg::result_t    out_res;

  logic                accept;
  logic                noop;
  logic                scan_issue;
  logic                scan_last;
  logic                load_out;
  logic                do_write;
  logic [IDX_W-1:0]    ins_slot;
  logic [IDX_W-1:0]    wr_slot;
  logic [HB-1:0]       wr_handle;
  logic [SB-1:0]       gen_inc;

  logic                ram_we;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic                eff_valid;
  logic [KEY_BITS-1:0] eff_key;
  logic [HB-1:0]       eff_handle;
  logic [SB-1:0]       eff_stamp;
  logic                occupied;

  lsc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = req.valid && req.ready;
  assign noop       = !req.key_valid || (req.action == lsc_pkg::ACT_INSERT && req.handle_in == '0);
  assign scan_issue = (state == lsc_pkg::ST_SCAN) && (idx != CNT_W'(ENTRIES));
  assign scan_last  = cmp_valid && (cmp_idx == IDX_W'(LAST_IDX));
  assign gen_inc    = generation + SB'(1);

  assign eff_valid  = vld[cmp_idx];
  assign eff_key    = eff_valid ? ram_rdata[WORD_W-1 -: KEY_BITS] : '0;
  assign eff_handle = eff_valid ? ram_rdata[SB +: HB] : '0;
  assign eff_stamp  = eff_valid ? ram_rdata[SB-1:0] : '0;
  assign occupied   = eff_handle != '0;

  assign ins_slot  = free_found ? empty_slot : best_idx;
  assign wr_slot   = found ? match_idx : ins_slot;
  assign wr_handle = (act == lsc_pkg::ACT_INSERT) ? handle_r : match_handle;
  assign ram_wdata = {key_r, wr_handle, gen_inc};
  assign ram_raddr = idx[IDX_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      lsc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = noop ? lsc_pkg::ST_DONE : lsc_pkg::ST_SCAN;
        end
      end
      lsc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = lsc_pkg::ST_WRITE;
        end
      end
      lsc_pkg::ST_WRITE: begin
        state_next = lsc_pkg::ST_DONE;
      end
      lsc_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = lsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    ram_re    = 1'b0;
    do_write  = 1'b0;
    load_out  = 1'b0;
    case (state)
      lsc_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      lsc_pkg::ST_SCAN: begin
        ram_re = scan_issue;
      end
      lsc_pkg::ST_WRITE: begin
        do_write = found || (act == lsc_pkg::ACT_INSERT);
      end
      lsc_pkg::ST_DONE: begin
        load_out = !out_valid || rsp.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign ram_we = do_write;

  always_comb begin
    res_next.hit            = found;
    res_next.handle_out     = (act == lsc_pkg::ACT_LOOKUP && found) ? match_handle : '0;
    res_next.evicted_handle = '0;
    if (act == lsc_pkg::ACT_INSERT) begin
      if (found) begin
        res_next.evicted_handle = match_handle;
      end else if (!free_found) begin
        res_next.evicted_handle = best_handle;
      end
    end
    res_next.slot_used = do_write ? lsc_pkg::SLOT_BITS'(wr_slot) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lsc_pkg::ST_IDLE;
      idx        <= '0;
      cmp_valid  <= 1'b0;
      vld        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      generation <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx        <= '0;
        cmp_valid  <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end
      if (state == lsc_pkg::ST_SCAN) begin
        cmp_valid <= scan_issue;
        if (scan_issue) begin
          idx <= idx + CNT_W'(1);
        end
        if (cmp_valid) begin
          if (!found && occupied && eff_key == key_r) begin
            found <= 1'b1;
          end
          if (!free_found && !occupied) begin
            free_found <= 1'b1;
          end
        end
      end
      if (do_write) begin
        generation   <= gen_inc;
        vld[wr_slot] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act         <= req.action;
      key_r       <= req.key[KEY_BITS-1:0];
      handle_r    <= req.handle_in;
      best_stamp  <= '1;
      best_idx    <= '0;
      best_handle <= '0;
      res         <= '0;
    end
    if (state == lsc_pkg::ST_SCAN) begin
      if (scan_issue) begin
        cmp_idx <= idx[IDX_W-1:0];
      end
      if (cmp_valid) begin
        if (!found && occupied && eff_key == key_r) begin
          match_idx    <= cmp_idx;
          match_handle <= eff_handle;
        end
        if (!free_found && !occupied) begin
          empty_slot <= cmp_idx;
        end
        if (cmp_idx == '0 || eff_stamp < best_stamp) begin
          best_stamp  <= eff_stamp;
          best_idx    <= cmp_idx;
          best_handle <= eff_handle;
        end
      end
    end
    if (state == lsc_pkg::ST_WRITE) begin
      res <= res_next;
    end
    if (load_out) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.hit            = out_res.hit;
  assign rsp.handle_out     = out_res.handle_out;
  assign rsp.evicted_handle = out_res.evicted_handle;
  assign rsp.slot_used      = out_res.slot_used;

endmodule

`default_nettype wire

// ----- design/lsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lsc_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/lsc_checker.sv -----
// Port-level checker of the session cache and its binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lsc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic                            rsp_hit,
  input wire logic [lsc_pkg::HANDLE_BITS-1:0] rsp_handle_out,
  input wire logic [lsc_pkg::HANDLE_BITS-1:0] rsp_evicted_handle,
  input wire logic [lsc_pkg::SLOT_BITS-1:0]   rsp_slot_used
);

`include "assert_macros.svh"

  // The cache is not ready again in the cycle after it accepts a request.
  `LSC_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)

  // A response that is not a hit returns no handle.
  `LSC_ASSERT_IMP(a_miss_no_handle, rsp_valid && !rsp_hit, rsp_handle_out == '0)

  // A lookup hit never displaces a handle.
  `LSC_ASSERT_IMP(a_lookup_clean, rsp_valid && rsp_handle_out != '0, rsp_hit && rsp_evicted_handle == '0)

  // A stalled response stays valid and holds its handles and slot.
  `LSC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_handle_out) && $stable(rsp_evicted_handle) && $stable(rsp_slot_used))

endmodule

bind lru_session_cache lsc_checker u_lsc_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_hit            (rsp.hit),
  .rsp_handle_out     (rsp.handle_out),
  .rsp_evicted_handle (rsp.evicted_handle),
  .rsp_slot_used      (rsp.slot_used)
);

`default_nettype wire

// ----- tb/lru_session_cache_tb.sv -----
// Testbench of the session cache: a directed table and random requests, checked against a predictor.
`timescale 1ns / 1ps

module lru_session_cache_tb;

  localparam int CACHE_ENTRIES  = 16;
  localparam int CACHE_KEY_BITS = 64;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - CACHE_KEY_BITS);
  localparam int RANDOM_REQUESTS = 580;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 2 * (CACHE_ENTRIES + 4);
  localparam int CYCLE_LIMIT     = 200000;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct {
    logic             act;
    logic             kv;
    logic [63:0]      key;
    logic [63:0]      handle;
    logic             typed;
    lsc_pkg::result_t want;
  } cache_request_t;

  logic clk = 1'b0;
  logic rst;

  lsc_req_if req_ch ();
  lsc_rsp_if rsp_ch ();

  lru_session_cache #(
    .ENTRIES  (CACHE_ENTRIES),
    .KEY_BITS (CACHE_KEY_BITS)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  logic [63:0] cached_key    [CACHE_ENTRIES];
  logic [63:0] cached_handle [CACHE_ENTRIES];
  logic [31:0] cached_stamp  [CACHE_ENTRIES];
  logic [31:0] generation_count;

  lsc_pkg::result_t pending_results [$];
  cache_request_t   directed_rows [$];
  logic [63:0]      key_pool [KEY_POOL_SIZE];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   hold_count;
  logic idle_allowed = 1'b1;
  logic long_hold = 1'b0;
  lsc_pkg::result_t oldest_result;

  function automatic lsc_pkg::result_t predict_access(input logic act, input logic kv,
                                                      input logic [63:0] key_raw,
                                                      input logic [63:0] handle);
    lsc_pkg::result_t res;
    logic [63:0]      k;
    int               match_idx;
    int               empty_idx;
    int               old_idx;
    logic [31:0]      old_stamp;
    int               slot;
    res = '0;
    k = key_raw & KEY_MASK;
    if (!kv) return res;
    if (act == lsc_pkg::ACT_INSERT && handle == 64'd0) return res;
    match_idx = -1;
    empty_idx = -1;
    old_idx = 0;
    old_stamp = '1;
    for (int i = 0; i < CACHE_ENTRIES && match_idx < 0; i++) begin
      if (cached_handle[i] != 64'd0 && cached_key[i] == k) begin
        match_idx = i;
      end else begin
        if (cached_handle[i] == 64'd0 && empty_idx < 0) empty_idx = i;
        if (cached_stamp[i] < old_stamp) begin
          old_stamp = cached_stamp[i];
          old_idx = i;
        end
      end
    end
    if (act == lsc_pkg::ACT_LOOKUP) begin
      if (match_idx >= 0) begin
        generation_count = generation_count + 32'd1;
        cached_stamp[match_idx] = generation_count;
        res.hit = 1'b1;
        res.handle_out = cached_handle[match_idx];
        res.slot_used = match_idx[lsc_pkg::SLOT_BITS-1:0];
      end
      return res;
    end
    if (match_idx >= 0) begin
      res.hit = 1'b1;
      res.evicted_handle = cached_handle[match_idx];
      cached_handle[match_idx] = handle;
      generation_count = generation_count + 32'd1;
      cached_stamp[match_idx] = generation_count;
      res.slot_used = match_idx[lsc_pkg::SLOT_BITS-1:0];
      return res;
    end
    slot = (empty_idx >= 0) ? empty_idx : old_idx;
    res.evicted_handle = cached_handle[slot];
    cached_key[slot] = k;
    cached_handle[slot] = handle;
    generation_count = generation_count + 32'd1;
    cached_stamp[slot] = generation_count;
    res.slot_used = slot[lsc_pkg::SLOT_BITS-1:0];
    return res;
  endfunction

  function automatic cache_request_t make_row(input logic act, input logic kv,
                                              input logic [63:0] key,
                                              input logic [63:0] handle,
                                              input logic typed,
                                              input lsc_pkg::result_t want);
    cache_request_t rq;
    rq.act = act;
    rq.kv = kv;
    rq.key = key;
    rq.handle = handle;
    rq.typed = typed;
    rq.want = want;
    return rq;
  endfunction

  task automatic send_request(input cache_request_t rq);
    lsc_pkg::result_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.action <= rq.act;
    req_ch.key_valid <= rq.kv;
    req_ch.key <= rq.key;
    req_ch.handle_in <= rq.handle;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_access(rq.act, rq.kv, rq.key, rq.handle);
    pending_results.push_back(rq.typed ? rq.want : predicted);
  endtask

  task automatic sender_gap();
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_allowed && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding: slot_used %0d", rsp_ch.slot_used);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_ch.hit !== oldest_result.hit) begin
          $error("hit: expected %0h, actual %0h", oldest_result.hit, rsp_ch.hit);
          mismatch_count++;
        end
        if (rsp_ch.handle_out !== oldest_result.handle_out) begin
          $error("handle_out: expected %0h, actual %0h", oldest_result.handle_out,
                 rsp_ch.handle_out);
          mismatch_count++;
        end
        if (rsp_ch.evicted_handle !== oldest_result.evicted_handle) begin
          $error("evicted_handle: expected %0h, actual %0h", oldest_result.evicted_handle,
                 rsp_ch.evicted_handle);
          mismatch_count++;
        end
        if (rsp_ch.slot_used !== oldest_result.slot_used) begin
          $error("slot_used: expected %0h, actual %0h", oldest_result.slot_used,
                 rsp_ch.slot_used);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cache_request_t   rq;
    lsc_pkg::result_t none;
    int               accepted;
    int               pick;
    none = '0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = lsc_pkg::ACT_LOOKUP;
    req_ch.key_valid = 1'b0;
    req_ch.key = '0;
    req_ch.handle_in = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      cached_key[i] = '0;
      cached_handle[i] = '0;
      cached_stamp[i] = '0;
    end
    generation_count = '0;
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'd0;
    key_pool[1] = ALL_ONES;

    directed_rows.push_back(make_row(lsc_pkg::ACT_LOOKUP, 1'b1, 64'd0, 64'd0, 1'b1, none));
    directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b0, ALL_ONES, ALL_ONES, 1'b1,
                                     none));
    directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b1, 64'd5, 64'd0, 1'b1, none));
    directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b1, 64'd0, ALL_ONES, 1'b1,
                                     none));
    directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b1, ALL_ONES, 64'd1, 1'b1,
                                     '{1'b0, 64'd0, 64'd0, 4'd1}));
    directed_rows.push_back(make_row(lsc_pkg::ACT_LOOKUP, 1'b1, ALL_ONES, 64'd0, 1'b1,
                                     '{1'b1, 64'd1, 64'd0, 4'd1}));
    directed_rows.push_back(make_row(lsc_pkg::ACT_LOOKUP, 1'b1, 64'd0, 64'd0, 1'b1,
                                     '{1'b1, ALL_ONES, 64'd0, 4'd0}));
    directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b1, 64'd0,
                                     64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
                                     '{1'b1, 64'd0, ALL_ONES, 4'd0}));
    directed_rows.push_back(make_row(lsc_pkg::ACT_LOOKUP, 1'b0, 64'd0, ALL_ONES, 1'b1,
                                     none));
    for (int i = 2; i < CACHE_ENTRIES; i++) begin
      directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b1,
                                       64'h5555_5555_5555_5555 + i,
                                       64'h8000_0000_0000_0000 | i, 1'b0, none));
    end
    directed_rows.push_back(make_row(lsc_pkg::ACT_INSERT, 1'b1, 64'h0123_4567_89AB_CDEF,
                                     64'h7FFF_FFFF_FFFF_FFFF, 1'b0, none));
    directed_rows.push_back(make_row(lsc_pkg::ACT_LOOKUP, 1'b1, ALL_ONES, 64'd0, 1'b0,
                                     none));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
      sender_gap();
    end

    accepted = 0;
    while (accepted < RANDOM_REQUESTS) begin
      rq.act = 1'($urandom_range(0, 1));
      rq.kv = ($urandom_range(0, 19) != 0);
      pick = $urandom_range(0, 19);
      rq.key = (pick < 17) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                           : {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      rq.handle = (pick == 0) ? 64'd0 : (pick == 1) ? ALL_ONES : {$urandom, $urandom};
      rq.typed = 1'b0;
      rq.want = none;
      send_request(rq);
      if (rq.kv && !(rq.act == lsc_pkg::ACT_INSERT && rq.handle == 64'd0)) accepted++;
      if (accepted == 200 && !long_hold && hold_count == 0) long_hold = 1'b1;
      if (accepted == 400) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        accepted++;
      end
      if (accepted >= RANDOM_REQUESTS - 60) idle_allowed = 1'b0;
      sender_gap();
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
